@@ design/cdq_pkg.sv @@
// ----------------------------------------------------------------------------
// cdq_pkg
// Shared types, sizes and ring-pointer helpers for the circular deque.
// ----------------------------------------------------------------------------
package cdq_pkg;

  // built storage size and entry width
  localparam int DEPTH      = 16;
  localparam int DATA_WIDTH = 32;

  // fixed field widths of the ports
  localparam int OP_W  = 3;
  localparam int VAL_W = 32;
  localparam int CFG_W = 5;
  localparam int CNT_O = 5;

  // internal widths derived from the depth
  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  // capacity after reset
  localparam logic [CFG_W-1:0] CAP_RESET = 5'd16;

  typedef logic [IDX_W-1:0] idx_t;
  typedef logic [CNT_W-1:0] cnt_t;

  // operation codes
  typedef enum logic [OP_W-1:0] {
    OP_QUERY      = 3'd0,
    OP_PUSH_FRONT = 3'd1,
    OP_PUSH_BACK  = 3'd2,
    OP_POP_FRONT  = 3'd3,
    OP_POP_BACK   = 3'd4
  } op_t;

  // controller states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_READ,
    ST_DONE
  } state_t;

  // commands from controller to datapath
  typedef struct packed {
    logic load;
    logic exec;
    logic rd;
  } cdq_cmd_t;

  // step one slot toward the front, wrapping at the capacity in use
  function automatic idx_t step_back(input idx_t idx, input cnt_t cap);
    idx_t res;
    if (idx == '0) begin
      res = IDX_W'(cap - cnt_t'(1));
    end else begin
      res = idx - idx_t'(1);
    end
    return res;
  endfunction

  // step one slot toward the rear, wrapping at the capacity in use
  function automatic idx_t step_fwd(input idx_t idx, input cnt_t cap);
    cnt_t nxt;
    idx_t res;
    nxt = CNT_W'(idx) + cnt_t'(1);
    if (nxt >= cap) begin
      res = '0;
    end else begin
      res = IDX_W'(nxt);
    end
    return res;
  endfunction

endpackage

@@ design/cdq_ram.sv @@
// ----------------------------------------------------------------------------
// cdq_ram
// Generic RAM: one write port, two read ports with registered read data.
// ----------------------------------------------------------------------------
module cdq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                                      clk,
  input  logic                                      we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                          wdata,
  input  logic                                      re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_a,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_b,
  output logic [WIDTH-1:0]                          rdata_a_r,
  output logic [WIDTH-1:0]                          rdata_b_r
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read ports
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_a_r <= mem[raddr_a];
      rdata_b_r <= mem[raddr_b];
    end
  end

endmodule

@@ design/cdq_ctrl.sv @@
// ----------------------------------------------------------------------------
// cdq_ctrl
// Sequencer: accept an item, update pointers, read the ends, emit result.
// ----------------------------------------------------------------------------
module cdq_ctrl
  import cdq_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  output logic     busy,
  output logic     out_strobe,
  output cdq_cmd_t cmd
);

  state_t state_r, state_nxt;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state and commands
  always_comb begin
    state_nxt  = state_r;
    busy       = 1'b0;
    out_strobe = 1'b0;
    cmd        = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        busy      = 1'b1;
        cmd.exec  = 1'b1;
        state_nxt = ST_READ;
      end
      ST_READ: begin
        busy      = 1'b1;
        cmd.rd    = 1'b1;
        state_nxt = ST_DONE;
      end
      ST_DONE: begin
        out_strobe = 1'b1;
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = ST_EXEC;
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

@@ design/cdq_dp.sv @@
// ----------------------------------------------------------------------------
// cdq_dp
// Datapath: capacity, head/tail pointers, count and the slot memory.
// ----------------------------------------------------------------------------
module cdq_dp
  import cdq_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  cdq_cmd_t                cmd,
  input  logic [OP_W-1:0]         in_opcode,
  input  logic signed [VAL_W-1:0] in_value,
  input  logic                    cfg_we,
  input  logic [CFG_W-1:0]        cfg_wdata,
  output logic                    out_success,
  output logic signed [VAL_W-1:0] out_front_value,
  output logic signed [VAL_W-1:0] out_rear_value,
  output logic                    out_empty_res,
  output logic                    out_full_res,
  output logic [CNT_O-1:0]        out_count
);

  logic [OP_W-1:0]       op_r;
  logic [VAL_W-1:0]      val_r;
  logic [CFG_W-1:0]      cap_r;
  idx_t                  head_r, head_nxt;
  idx_t                  tail_r, tail_nxt;
  cnt_t                  cnt_r, cnt_nxt;
  logic                  ok_r, ok_nxt;
  cnt_t                  cap_use;
  logic                  has_room, non_empty;
  logic                  ram_we;
  idx_t                  ram_waddr;
  logic [DATA_WIDTH-1:0] rdata_a, rdata_b;

  // item capture
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r  <= in_opcode;
      val_r <= in_value;
    end
  end

  // capacity in use: zero reads as one, large values saturate
  always_comb begin
    if (cap_r == '0) begin
      cap_use = cnt_t'(1);
    end else if (int'(cap_r) > DEPTH) begin
      cap_use = cnt_t'(DEPTH);
    end else begin
      cap_use = CNT_W'(cap_r);
    end
  end

  assign has_room  = (cnt_r < cap_use);
  assign non_empty = (cnt_r != '0);

  // operation decode and pointer update
  always_comb begin
    head_nxt  = head_r;
    tail_nxt  = tail_r;
    cnt_nxt   = cnt_r;
    ok_nxt    = 1'b0;
    ram_we    = 1'b0;
    ram_waddr = tail_r;
    unique case (op_t'(op_r))
      OP_QUERY: begin
        ok_nxt = 1'b1;
      end
      OP_PUSH_FRONT: begin
        if (has_room) begin
          head_nxt  = step_back(head_r, cap_use);
          ram_waddr = step_back(head_r, cap_use);
          ram_we    = 1'b1;
          cnt_nxt   = cnt_r + cnt_t'(1);
          ok_nxt    = 1'b1;
        end
      end
      OP_PUSH_BACK: begin
        if (has_room) begin
          ram_waddr = tail_r;
          ram_we    = 1'b1;
          tail_nxt  = step_fwd(tail_r, cap_use);
          cnt_nxt   = cnt_r + cnt_t'(1);
          ok_nxt    = 1'b1;
        end
      end
      OP_POP_FRONT: begin
        if (non_empty) begin
          head_nxt = step_fwd(head_r, cap_use);
          cnt_nxt  = cnt_r - cnt_t'(1);
          ok_nxt   = 1'b1;
        end
      end
      OP_POP_BACK: begin
        if (non_empty) begin
          tail_nxt = step_back(tail_r, cap_use);
          cnt_nxt  = cnt_r - cnt_t'(1);
          ok_nxt   = 1'b1;
        end
      end
      default: begin
        ok_nxt = 1'b0;
      end
    endcase
  end

  // control state; a capacity write empties the deque
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r  <= CAP_RESET;
      head_r <= '0;
      tail_r <= '0;
      cnt_r  <= '0;
      ok_r   <= 1'b0;
    end else if (cfg_we) begin
      cap_r  <= cfg_wdata;
      head_r <= '0;
      tail_r <= '0;
      cnt_r  <= '0;
    end else if (cmd.exec) begin
      head_r <= head_nxt;
      tail_r <= tail_nxt;
      cnt_r  <= cnt_nxt;
      ok_r   <= ok_nxt;
    end
  end

  // slot memory, ends read in the cycle after the update
  cdq_ram #(
    .WIDTH (DATA_WIDTH),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk       (clk),
    .we        (cmd.exec && ram_we),
    .waddr     (ram_waddr),
    .wdata     (DATA_WIDTH'(val_r)),
    .re        (cmd.rd),
    .raddr_a   (head_r),
    .raddr_b   (step_back(tail_r, cap_use)),
    .rdata_a_r (rdata_a),
    .rdata_b_r (rdata_b)
  );

  // result fields
  assign out_success     = ok_r;
  assign out_front_value = non_empty ? VAL_W'(rdata_a) : '0;
  assign out_rear_value  = non_empty ? VAL_W'(rdata_b) : '0;
  assign out_empty_res   = !non_empty;
  assign out_full_res    = (cnt_r == cap_use);
  assign out_count       = CNT_O'(cnt_r);

endmodule

@@ design/circular_deque.sv @@
// ----------------------------------------------------------------------------
// circular_deque
// Double-ended queue in a ring of slots with a programmable capacity.
// ----------------------------------------------------------------------------
// the result strobe follows the update and memory read after an item is taken,
// and no new item is taken before it; update, memory read and result cycles
//   follow each other, and the next item is taken in the result cycle
// the receiver cannot stall; each result is shown for exactly one cycle
// reset (rst_n low, synchronous): deque empty, capacity 16, no result pending
module circular_deque
  import cdq_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  output logic                    busy,
  input  logic [OP_W-1:0]         in_opcode,
  input  logic signed [VAL_W-1:0] in_value,
  input  logic                    cfg_we,
  input  logic [CFG_W-1:0]        cfg_wdata,
  output logic                    out_strobe,
  output logic                    out_success,
  output logic signed [VAL_W-1:0] out_front_value,
  output logic signed [VAL_W-1:0] out_rear_value,
  output logic                    out_empty_res,
  output logic                    out_full_res,
  output logic [CNT_O-1:0]        out_count
);

  cdq_cmd_t cmd;

  // sequencer
  cdq_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .out_strobe (out_strobe),
    .cmd        (cmd)
  );

  // pointers, count and storage
  cdq_dp u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .in_opcode       (in_opcode),
    .in_value        (in_value),
    .cfg_we          (cfg_we),
    .cfg_wdata       (cfg_wdata),
    .out_success     (out_success),
    .out_front_value (out_front_value),
    .out_rear_value  (out_rear_value),
    .out_empty_res   (out_empty_res),
    .out_full_res    (out_full_res),
    .out_count       (out_count)
  );

  // every taken item gives its result after the update and memory read states
  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##3 out_strobe)
    else $error("item taken without a result three cycles later");

  // capacity is at least one, so a result is never both empty and full
  a_not_empty_and_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> !(out_empty_res && out_full_res))
    else $error("result flagged empty and full together");

  // results are spaced by the sequence length; this checks that no result strobe directly follows another
  a_strobe_spacing: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |=> !out_strobe)
    else $error("result strobe on two cycles in a row");

endmodule

@@ tb/sv/circular_deque_checker.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// circular_deque_checker
// Watches the item and result channels of the circular deque, keeps its own
// ring model with capacity, head, tail and entry count, predicts one result
// per accepted item and compares every result field by field in order.
// ----------------------------------------------------------------------------
module circular_deque_checker
  import cdq_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  input  logic                    busy,
  input  logic [OP_W-1:0]         in_opcode,
  input  logic signed [VAL_W-1:0] in_value,
  input  logic                    cfg_we,
  input  logic [CFG_W-1:0]        cfg_wdata,
  input  logic                    out_strobe,
  input  logic                    out_success,
  input  logic signed [VAL_W-1:0] out_front_value,
  input  logic signed [VAL_W-1:0] out_rear_value,
  input  logic                    out_empty_res,
  input  logic                    out_full_res,
  input  logic [CNT_O-1:0]        out_count,
  output int                      fails,
  output int                      pending
);

  typedef struct packed {
    logic             success;
    logic [VAL_W-1:0] front;
    logic [VAL_W-1:0] rear;
    logic             empty;
    logic             full;
    logic [CNT_O-1:0] count;
  } deque_result_t;

  // model state
  logic [VAL_W-1:0] ring [DEPTH];
  int unsigned      head;
  int unsigned      tail;
  int unsigned      held;
  logic [CFG_W-1:0] cap_reg;
  deque_result_t    deque_results[$];

  // ring index helpers, wrapping at the capacity in use
  function automatic int unsigned wrap_back(input int unsigned idx, input int unsigned cap);
    return (idx == 0) ? cap - 1 : idx - 1;
  endfunction

  function automatic int unsigned wrap_fwd(input int unsigned idx, input int unsigned cap);
    return (idx + 1 >= cap) ? 0 : idx + 1;
  endfunction

  // apply one item to the model and return the result it should produce
  function automatic deque_result_t deque_step(input logic [OP_W-1:0] op,
                                               input logic [VAL_W-1:0] val);
    int unsigned   cap;
    deque_result_t r;
    // zero capacity acts as one, anything above the built depth saturates
    if (cap_reg == '0) begin
      cap = 1;
    end else if (cap_reg > DEPTH) begin
      cap = DEPTH;
    end else begin
      cap = cap_reg;
    end
    r = '0;
    case (op)
      OP_QUERY: begin
        r.success = 1'b1;
      end
      OP_PUSH_FRONT: begin
        if (held < cap) begin
          head = wrap_back(head, cap);
          ring[head] = val;
          held++;
          r.success = 1'b1;
        end
      end
      OP_PUSH_BACK: begin
        if (held < cap) begin
          ring[tail] = val;
          tail = wrap_fwd(tail, cap);
          held++;
          r.success = 1'b1;
        end
      end
      OP_POP_FRONT: begin
        if (held != 0) begin
          head = wrap_fwd(head, cap);
          held--;
          r.success = 1'b1;
        end
      end
      OP_POP_BACK: begin
        if (held != 0) begin
          tail = wrap_back(tail, cap);
          held--;
          r.success = 1'b1;
        end
      end
      default: begin
        r.success = 1'b0;
      end
    endcase
    // front and rear read as zero when nothing is held
    if (held != 0) begin
      r.front = ring[head];
      r.rear  = ring[wrap_back(tail, cap)];
    end
    r.empty = (held == 0);
    r.full  = (held == cap);
    r.count = CNT_O'(held);
    return r;
  endfunction

  task automatic flag_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $time, msg);
    fails++;
  endtask

  // sample both channels at the clock edge that accepts them
  always @(posedge clk) begin
    deque_result_t want;
    if (!rst_n) begin
      head = 0;
      tail = 0;
      held = 0;
      cap_reg = CAP_RESET;
      deque_results.delete();
      fails = 0;
    end else begin
      // result side
      if (out_strobe) begin
        if (deque_results.size() == 0) begin
          flag_mismatch("result with no item outstanding");
        end else begin
          want = deque_results.pop_front();
          if (out_success !== want.success)
            flag_mismatch($sformatf("success got %b expected %b", out_success, want.success));
          if (out_front_value !== want.front)
            flag_mismatch($sformatf("front_value got %h expected %h",
                                    out_front_value, want.front));
          if (out_rear_value !== want.rear)
            flag_mismatch($sformatf("rear_value got %h expected %h",
                                    out_rear_value, want.rear));
          if (out_empty_res !== want.empty)
            flag_mismatch($sformatf("empty_res got %b expected %b", out_empty_res, want.empty));
          if (out_full_res !== want.full)
            flag_mismatch($sformatf("full_res got %b expected %b", out_full_res, want.full));
          if (out_count !== want.count)
            flag_mismatch($sformatf("count got %0d expected %0d", out_count, want.count));
        end
      end
      // capacity write empties the deque
      if (cfg_we) begin
        cap_reg = cfg_wdata;
        head = 0;
        tail = 0;
        held = 0;
      end
      // item side
      if (start && !busy) begin
        deque_results.push_back(deque_step(in_opcode, in_value));
      end
    end
    pending <= deque_results.size();
  end

endmodule

@@ tb/sv/circular_deque_test.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// circular_deque_test
// Drives the circular deque with a directed opening on empty, full and
// refused cases and unknown opcodes, then random push/pop runs over several
// capacities and sender idle rates; the checker predicts and compares.
// ----------------------------------------------------------------------------
module circular_deque_test;
  import cdq_pkg::*;

  localparam int               RUN_LIMIT = 200_000;
  localparam int               SEGMENTS  = 12;
  localparam int               SEG_ITEMS = 100;
  // opcodes past the last defined one
  localparam logic [OP_W-1:0]  OP_BAD_LO = OP_W'(OP_POP_BACK) + OP_W'(1);
  localparam logic [OP_W-1:0]  OP_BAD_HI = '1;

  logic                    clk;
  logic                    rst_n     = 1'b0;
  logic                    start     = 1'b0;
  logic                    busy;
  logic [OP_W-1:0]         in_opcode = '0;
  logic signed [VAL_W-1:0] in_value  = '0;
  logic                    cfg_we    = 1'b0;
  logic [CFG_W-1:0]        cfg_wdata = '0;
  logic                    out_strobe;
  logic                    out_success;
  logic signed [VAL_W-1:0] out_front_value;
  logic signed [VAL_W-1:0] out_rear_value;
  logic                    out_empty_res;
  logic                    out_full_res;
  logic [CNT_O-1:0]        out_count;
  int                      fails;
  int                      pending;
  int                      idle_pct = 0;
  int                      cycles   = 0;

  circular_deque i_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_opcode       (in_opcode),
    .in_value        (in_value),
    .cfg_we          (cfg_we),
    .cfg_wdata       (cfg_wdata),
    .out_strobe      (out_strobe),
    .out_success     (out_success),
    .out_front_value (out_front_value),
    .out_rear_value  (out_rear_value),
    .out_empty_res   (out_empty_res),
    .out_full_res    (out_full_res),
    .out_count       (out_count)
  );

  circular_deque_checker i_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_opcode       (in_opcode),
    .in_value        (in_value),
    .cfg_we          (cfg_we),
    .cfg_wdata       (cfg_wdata),
    .out_strobe      (out_strobe),
    .out_success     (out_success),
    .out_front_value (out_front_value),
    .out_rear_value  (out_rear_value),
    .out_empty_res   (out_empty_res),
    .out_full_res    (out_full_res),
    .out_count       (out_count),
    .fails           (fails),
    .pending         (pending)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // run limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > RUN_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // offer one item after a random gap and hold it until the block takes it
  task automatic send_item(input logic [OP_W-1:0] op, input logic [VAL_W-1:0] val);
    if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < idle_pct) @(posedge clk);
    end
    start     <= 1'b1;
    in_opcode <= op;
    in_value  <= val;
    do @(posedge clk); while (busy);
  endtask

  // drain all outstanding results, then write the capacity
  task automatic write_capacity(input logic [CFG_W-1:0] cap);
    start <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= cap;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  initial begin
    logic [OP_W-1:0]  op;
    logic [VAL_W-1:0] val;
    logic [CFG_W-1:0] cap;
    int               push_pct;
    int               roll;

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: empty pops, extreme values, unknown opcodes at full depth
    send_item(OP_QUERY, '0);
    send_item(OP_POP_FRONT, '0);
    send_item(OP_POP_BACK, '0);
    send_item(OP_PUSH_FRONT, 32'h7FFF_FFFF);
    send_item(OP_PUSH_BACK, 32'h8000_0000);
    send_item(OP_PUSH_FRONT, 32'h0000_0000);
    send_item(OP_PUSH_BACK, 32'hFFFF_FFFF);
    send_item(OP_QUERY, 32'h5555_5555);
    send_item(OP_BAD_LO, 32'h1234_5678);
    send_item(OP_BAD_LO + OP_W'(1), 32'h1234_5678);
    send_item(OP_BAD_HI, 32'h1234_5678);
    send_item(OP_POP_BACK, '0);
    send_item(OP_POP_FRONT, '0);
    send_item(OP_POP_FRONT, '0);
    send_item(OP_POP_BACK, '0);

    // directed: single slot, full refusals
    write_capacity(CFG_W'(1));
    send_item(OP_PUSH_BACK, 32'h1234_5678);
    send_item(OP_PUSH_FRONT, 32'hDEAD_BEEF);
    send_item(OP_PUSH_BACK, 32'hDEAD_BEEF);
    send_item(OP_POP_FRONT, '0);
    send_item(OP_POP_BACK, '0);

    // directed: zero capacity behaves as one
    write_capacity('0);
    send_item(OP_PUSH_FRONT, 32'hAAAA_AAAA);
    send_item(OP_PUSH_FRONT, 32'h5555_5555);
    send_item(OP_POP_BACK, '0);

    // random runs, one capacity and idle rate per segment
    for (int seg = 0; seg < SEGMENTS; seg++) begin
      case (seg)
        0: cap = CFG_W'(DEPTH);
        1: cap = CFG_W'(1);
        2: cap = '0;
        3: cap = '1;
        4: cap = CFG_W'(2);
        5: cap = CFG_W'(DEPTH + 1);
        default: cap = CFG_W'($urandom_range(DEPTH, 1));
      endcase
      write_capacity(cap);
      case (seg % 3)
        0: idle_pct = 0;
        1: idle_pct = 58;
        default: idle_pct = 17;
      endcase
      // alternate between filling and draining pressure
      push_pct = (seg % 2 == 0) ? $urandom_range(80, 55) : $urandom_range(45, 20);
      for (int n = 0; n < SEG_ITEMS; n++) begin
        roll = $urandom_range(99);
        if (roll < 4) begin
          op = OP_QUERY;
        end else if (roll < 7) begin
          op = OP_W'($urandom_range(OP_BAD_HI, OP_BAD_LO));
        end else if ($urandom_range(99) < push_pct) begin
          op = $urandom_range(1) ? OP_PUSH_FRONT : OP_PUSH_BACK;
        end else begin
          op = $urandom_range(1) ? OP_POP_FRONT : OP_POP_BACK;
        end
        if ($urandom_range(9) == 0) begin
          case ($urandom_range(3))
            0: val = 32'h8000_0000;
            1: val = 32'h7FFF_FFFF;
            2: val = '0;
            default: val = '1;
          endcase
        end else begin
          val = $urandom;
        end
        send_item(op, val);
      end
    end

    // drain and give the verdict
    start <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (fails == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
